### rtl/tsn_pkg.sv
// ----------------------------------------------------------------------------
// tsn_pkg
// Shared constants and types for the triangle surface normal pipeline.
// ----------------------------------------------------------------------------
package tsn_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NORM_W          = 30;   // normalized magnitude, [2^29, 2^30)
  localparam int RAD_W           = 2 * NORM_W + 2;
  localparam int ROOT_W          = NORM_W + 1;
  localparam int UNIT_W          = 32;   // Q2.30 signed
  localparam int PROD_W          = 64;
  localparam int CLIP_W          = 31;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CLIP_W-1:0] CLIP_RESET = 31'd1074;

  typedef enum logic {
    REG_CLIP_THRESHOLD = 1'b0
  } reg_idx_t;

  typedef logic signed [UNIT_W-1:0] unit_t;

endpackage

### rtl/triangle_surface_normal.sv
// ----------------------------------------------------------------------------
// triangle_surface_normal
// Unit face normal of a triangle from three Q16.16 vertices, result in Q2.30.
// ----------------------------------------------------------------------------
// A triangle is taken on every cycle that start is high; busy stays low. Each
// triangle gives one result, flagged by out_valid for one cycle, in order.
// Most of the pipeline lies in the two normalizer passes (edges in parallel,
// then the cross product), each 68 stages deep, mostly the bit-per-stage
// square root and divider. Results cannot be held off, so the receiver must
// take every out_valid beat. clip_threshold sits at byte address 0 and
// should only be written while no triangle is in flight.
// ----------------------------------------------------------------------------
module triangle_surface_normal
  import tsn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] in_v1_x,
  input  logic [COORD_WIDTH-1:0] in_v1_y,
  input  logic [COORD_WIDTH-1:0] in_v1_z,
  input  logic [COORD_WIDTH-1:0] in_v2_x,
  input  logic [COORD_WIDTH-1:0] in_v2_y,
  input  logic [COORD_WIDTH-1:0] in_v2_z,
  input  logic [COORD_WIDTH-1:0] in_v3_x,
  input  logic [COORD_WIDTH-1:0] in_v3_y,
  input  logic [COORD_WIDTH-1:0] in_v3_z,
  output logic                   out_valid,
  output logic [UNIT_W-1:0]      out_normal_x,
  output logic [UNIT_W-1:0]      out_normal_y,
  output logic [UNIT_W-1:0]      out_normal_z,
  output logic                   out_degenerate
);

  localparam int EW = COORD_WIDTH + 1;

  // config register
  logic [CLIP_W-1:0] clip_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= CLIP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CLIP_THRESHOLD: clip_r <= pwdata[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CLIP_THRESHOLD: prdata = CFG_DATA_W'(clip_r);
      default:            prdata = '0;
    endcase
  end

  // edges
  logic               e_vld_r;
  logic [2:0][EW-1:0] e1_r;
  logic [2:0][EW-1:0] e2_r;
  logic [2:0][EW-1:0] e1_nxt;
  logic [2:0][EW-1:0] e2_nxt;

  function automatic logic [EW-1:0] sub_ext(input logic [COORD_WIDTH-1:0] hi,
                                            input logic [COORD_WIDTH-1:0] lo);
    return {hi[COORD_WIDTH-1], hi} - {lo[COORD_WIDTH-1], lo};
  endfunction

  assign e1_nxt[0] = sub_ext(in_v2_x, in_v1_x);
  assign e1_nxt[1] = sub_ext(in_v2_y, in_v1_y);
  assign e1_nxt[2] = sub_ext(in_v2_z, in_v1_z);
  assign e2_nxt[0] = sub_ext(in_v3_x, in_v1_x);
  assign e2_nxt[1] = sub_ext(in_v3_y, in_v1_y);
  assign e2_nxt[2] = sub_ext(in_v3_z, in_v1_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    e1_r <= e1_nxt;
    e2_r <= e2_nxt;
  end

  // edge normalizers
  logic        a_vld;
  logic        b_vld;
  unit_t [2:0] a_unit;
  unit_t [2:0] b_unit;
  logic        a_zero;
  logic        b_zero;

  tsn_unit #(
    .SW (EW)
  ) u_unit_e1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e_vld_r),
    .in_vec   (e1_r),
    .out_vld  (a_vld),
    .out_unit (a_unit),
    .out_zero (a_zero)
  );

  tsn_unit #(
    .SW (EW)
  ) u_unit_e2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e_vld_r),
    .in_vec   (e2_r),
    .out_vld  (b_vld),
    .out_unit (b_unit),
    .out_zero (b_zero)
  );

  // a zero edge yields a zero unit vector, hence a zero cross product
  logic                   c_vld;
  logic [2:0][PROD_W-1:0] c_vec;

  tsn_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (a_vld && b_vld && (a_zero || !a_zero) && (b_zero || !b_zero)),
    .in_a    (a_unit),
    .in_b    (b_unit),
    .out_vld (c_vld),
    .out_c   (c_vec)
  );

  logic        n_vld;
  unit_t [2:0] n_unit;
  logic        n_zero;

  tsn_unit #(
    .SW (PROD_W)
  ) u_unit_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld),
    .in_vec   (c_vec),
    .out_vld  (n_vld),
    .out_unit (n_unit),
    .out_zero (n_zero)
  );

  // clip and output register
  logic                   out_vld_r;
  logic [2:0][UNIT_W-1:0] normal_r;
  logic                   degen_r;
  logic [2:0][UNIT_W-1:0] normal_nxt;

  always_comb begin
    logic [UNIT_W-1:0] nm;
    for (int i = 0; i < 3; i++) begin
      nm = n_unit[i][UNIT_W-1] ? UNIT_W'('0 - n_unit[i]) : UNIT_W'(n_unit[i]);
      normal_nxt[i] = (nm[CLIP_W-1:0] < clip_r) ? '0 : n_unit[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    normal_r <= normal_nxt;
    degen_r  <= n_zero;
  end

  assign out_valid      = out_vld_r;
  assign out_normal_x   = normal_r[0];
  assign out_normal_y   = normal_r[1];
  assign out_normal_z   = normal_r[2];
  assign out_degenerate = degen_r;

endmodule

### rtl/tsn_isqrt.sv
// ----------------------------------------------------------------------------
// tsn_isqrt
// Pipelined floor square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tsn_isqrt
  import tsn_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              vld_r  [STEPS];
  logic [RAD_W-1:0]  rad_r  [STEPS];
  logic [REM_W-1:0]  rem_r  [STEPS];
  logic [ROOT_W-1:0] root_r [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  pre;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign pre   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_comb begin
      if (pre >= trial) begin
        rem_nxt  = pre - trial;
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = pre;
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[k]  <= rad_in << 2;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1];
  assign out_side = side_r[STEPS-1];

endmodule

### rtl/tsn_divide.sv
// ----------------------------------------------------------------------------
// tsn_divide
// Three-lane pipelined restoring divider: (mag << 30) / root, one bit a stage.
// ----------------------------------------------------------------------------
module tsn_divide
  import tsn_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [2:0][NORM_W-1:0] in_mag,
  input  logic [ROOT_W-1:0]      in_div,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_vld,
  output logic [2:0][ROOT_W-1:0] out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int STEPS = ROOT_W;
  localparam int PRE_W = ROOT_W + 1;

  logic                   vld_r  [STEPS];
  logic [ROOT_W-1:0]      div_r  [STEPS];
  logic [2:0][ROOT_W-1:0] rem_r  [STEPS];
  logic [2:0][ROOT_W-1:0] quo_r  [STEPS];
  logic [SIDE_W-1:0]      side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                   vld_in;
    logic [ROOT_W-1:0]      div_in;
    logic [2:0][ROOT_W-1:0] quo_in;
    logic [2:0][PRE_W-1:0]  pre;
    logic [SIDE_W-1:0]      side_in;
    logic [2:0][ROOT_W-1:0] rem_nxt;
    logic [2:0][ROOT_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign div_in  = in_div;
      assign quo_in  = '0;
      assign side_in = in_side;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign pre[l] = PRE_W'(in_mag[l]);
      end
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign div_in  = div_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign pre[l] = {rem_r[k-1][l], 1'b0};
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (pre[l] >= {1'b0, div_in}) begin
          rem_nxt[l] = ROOT_W'(pre[l] - {1'b0, div_in});
          quo_nxt[l] = {quo_in[l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = pre[l][ROOT_W-1:0];
          quo_nxt[l] = {quo_in[l][ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      div_r[k]  <= div_in;
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_quo  = quo_r[STEPS-1];
  assign out_side = side_r[STEPS-1];

endmodule

### rtl/tsn_unit.sv
// ----------------------------------------------------------------------------
// tsn_unit
// Vector normalizer: scale to 30-bit magnitudes, sum of squares, floor root,
// per-component divide, giving a signed Q2.30 unit vector and a zero flag.
// ----------------------------------------------------------------------------
module tsn_unit
  import tsn_pkg::*;
#(
  parameter int SW = 33
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [2:0][SW-1:0] in_vec,
  output logic               out_vld,
  output unit_t [2:0]        out_unit,
  output logic               out_zero
);

  localparam int LZ_W   = $clog2(SW);
  localparam int EXT_W  = SW + NORM_W;
  localparam int SQ_W   = 2 * NORM_W;
  localparam int SIDE_W = 1 + 3 + 3 * NORM_W;

  // stage 0: magnitude and sign
  logic               s0_vld_r;
  logic [2:0][SW-1:0] s0_mag_r;
  logic [2:0]         s0_neg_r;
  logic [2:0][SW-1:0] s0_mag_nxt;
  logic [2:0]         s0_neg_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s0_neg_nxt[i] = in_vec[i][SW-1];
      s0_mag_nxt[i] = s0_neg_nxt[i] ? SW'('0 - in_vec[i]) : in_vec[i];
    end
  end

  // stage 1: leading-one position of the largest magnitude
  logic               s1_vld_r;
  logic [2:0][SW-1:0] s1_mag_r;
  logic [2:0]         s1_neg_r;
  logic [LZ_W-1:0]    s1_lz_r;
  logic               s1_zero_r;
  logic [SW-1:0]      or_mag;
  logic [LZ_W-1:0]    s1_lz_nxt;

  assign or_mag = s0_mag_r[0] | s0_mag_r[1] | s0_mag_r[2];

  always_comb begin
    s1_lz_nxt = '0;
    for (int i = 0; i < SW; i++) begin
      if (or_mag[i]) s1_lz_nxt = LZ_W'(SW - 1 - i);
    end
  end

  // stage 2: shift so the largest magnitude lies in [2^29, 2^30)
  logic                   s2_vld_r;
  logic [2:0][NORM_W-1:0] s2_sm_r;
  logic [2:0]             s2_neg_r;
  logic                   s2_zero_r;
  logic [2:0][NORM_W-1:0] s2_sm_nxt;

  always_comb begin
    logic [EXT_W-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext          = {s1_mag_r[i], {NORM_W{1'b0}}} << s1_lz_r;
      s2_sm_nxt[i] = ext[EXT_W-1 -: NORM_W];
    end
  end

  // stage 3: squares
  logic                   s3_vld_r;
  logic [2:0][NORM_W-1:0] s3_sm_r;
  logic [2:0]             s3_neg_r;
  logic                   s3_zero_r;
  logic [2:0][SQ_W-1:0]   s3_sq_r;

  // stage 4: sum of squares
  logic                   s4_vld_r;
  logic [2:0][NORM_W-1:0] s4_sm_r;
  logic [2:0]             s4_neg_r;
  logic                   s4_zero_r;
  logic [RAD_W-1:0]       s4_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_mag_r  <= s0_mag_nxt;
    s0_neg_r  <= s0_neg_nxt;
    s1_mag_r  <= s0_mag_r;
    s1_neg_r  <= s0_neg_r;
    s1_lz_r   <= s1_lz_nxt;
    s1_zero_r <= (or_mag == '0);
    s2_sm_r   <= s2_sm_nxt;
    s2_neg_r  <= s1_neg_r;
    s2_zero_r <= s1_zero_r;
    s3_sm_r   <= s2_sm_r;
    s3_neg_r  <= s2_neg_r;
    s3_zero_r <= s2_zero_r;
    for (int i = 0; i < 3; i++) begin
      s3_sq_r[i] <= SQ_W'(s2_sm_r[i]) * SQ_W'(s2_sm_r[i]);
    end
    s4_sm_r   <= s3_sm_r;
    s4_neg_r  <= s3_neg_r;
    s4_zero_r <= s3_zero_r;
    s4_sum_r  <= RAD_W'(s3_sq_r[0]) + RAD_W'(s3_sq_r[1]) + RAD_W'(s3_sq_r[2]);
  end

  // root
  logic                   sq_vld;
  logic [ROOT_W-1:0]      sq_root;
  logic [SIDE_W-1:0]      sq_side;
  logic [2:0][NORM_W-1:0] sq_sm;
  logic [2:0]             sq_neg;
  logic                   sq_zero;

  tsn_isqrt #(
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_rad   (s4_sum_r),
    .in_side  ({s4_zero_r, s4_neg_r, s4_sm_r}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign {sq_zero, sq_neg, sq_sm} = sq_side;

  // divide
  logic                   dv_vld;
  logic [2:0][ROOT_W-1:0] dv_quo;
  logic [3:0]             dv_side;
  logic [2:0]             dv_neg;
  logic                   dv_zero;

  tsn_divide #(
    .SIDE_W (4)
  ) u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_mag   (sq_sm),
    .in_div   (sq_root),
    .in_side  ({sq_zero, sq_neg}),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  assign {dv_zero, dv_neg} = dv_side;

  // sign restore
  logic        out_vld_r;
  unit_t [2:0] unit_r;
  logic        zero_r;
  unit_t [2:0] unit_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero) begin
        unit_nxt[i] = '0;
      end else if (dv_neg[i]) begin
        unit_nxt[i] = unit_t'('0 - UNIT_W'(dv_quo[i]));
      end else begin
        unit_nxt[i] = unit_t'(UNIT_W'(dv_quo[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    zero_r <= dv_zero;
  end

  assign out_vld  = out_vld_r;
  assign out_unit = unit_r;
  assign out_zero = zero_r;

endmodule

### rtl/tsn_cross.sv
// ----------------------------------------------------------------------------
// tsn_cross
// Two-stage cross product of two Q2.30 unit vectors: products, then differences.
// ----------------------------------------------------------------------------
module tsn_cross
  import tsn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  unit_t [2:0]            in_a,
  input  unit_t [2:0]            in_b,
  output logic                   out_vld,
  output logic [2:0][PROD_W-1:0] out_c
);

  logic                          p_vld_r;
  logic signed [5:0][PROD_W-1:0] prod_r;
  logic signed [5:0][PROD_W-1:0] prod_nxt;
  logic                          c_vld_r;
  logic [2:0][PROD_W-1:0]        c_r;

  assign prod_nxt[0] = PROD_W'(in_a[1] * in_b[2]);
  assign prod_nxt[1] = PROD_W'(in_a[2] * in_b[1]);
  assign prod_nxt[2] = PROD_W'(in_a[2] * in_b[0]);
  assign prod_nxt[3] = PROD_W'(in_a[0] * in_b[2]);
  assign prod_nxt[4] = PROD_W'(in_a[0] * in_b[1]);
  assign prod_nxt[5] = PROD_W'(in_a[1] * in_b[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
      c_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    c_r[0] <= prod_r[0] - prod_r[1];
    c_r[1] <= prod_r[2] - prod_r[3];
    c_r[2] <= prod_r[4] - prod_r[5];
  end

  assign out_vld = c_vld_r;
  assign out_c   = c_r;

endmodule
